// File: hw/rtl/websocket_frame_deframer_assert.svh
// Assertion macros used by the deframer parser RTL.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define WSD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication.
`define WSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`else

`define WSD_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define WSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hw/rtl/wsd_pkg.sv
package wsd_pkg;

    // Frame length carried once the header is accepted (limit resets to 2^16)
    localparam int LenW = 17;

    // Opcodes of interest
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // 7-bit length codes for extended lengths
    localparam logic [6:0] LEN7_EXT16 = 7'd126;

    // Configuration register indexes
    localparam logic REG_MAX_LEN = 1'b0;

    localparam logic [LenW-1:0] MAX_LEN_RESET = 17'd65536;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DEAD    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_TEXT    = 3'd0,
        EV_EMPTY   = 3'd1,
        EV_PONG    = 3'd2,
        EV_CLOSE   = 3'd3,
        EV_TOOLONG = 3'd4
    } ev_kind_t;

    // One parse result, from parser to output stage
    typedef struct packed {
        logic       valid;
        ev_kind_t   kind;
        logic [7:0] data;
        logic       last;
    } wsd_result_t;

endpackage

// File: hw/rtl/websocket_frame_deframer.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_rx_byte[7:0]
// m_        out  m_valid/m_ready    m_event_kind[2:0], m_payload_byte[7:0], m_last_of_message
// apb       in   psel/penable       paddr[2:0], pwdata/prdata[31:0], reg 0 = max payload length
//
// One byte per cycle while s_ready is high: a byte is parsed in the cycle it is accepted and its
// result (if any) sits in the output register on the next cycle.
// s_ready drops only while a result is held and m_ready is low.
// aresetn is synchronous; reset restarts at the first header byte, no clearing pass.
// After a close frame or an oversized length, bytes are taken and dropped until reset.
module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [7:0]  m_payload_byte,
    output logic        m_last_of_message,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wsd_pkg::*;

    logic [LenW-1:0] max_len;
    logic            step;
    wsd_result_t     res;

    wsd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    wsd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (s_rx_byte),
        .max_len (max_len),
        .res     (res)
    );

    wsd_out_stage u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .step              (step),
        .res               (res),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_payload_byte    (m_payload_byte),
        .m_last_of_message (m_last_of_message)
    );

endmodule

// File: hw/rtl/wsd_cfg_regs.sv
module wsd_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [wsd_pkg::LenW-1:0]  max_len
);
    import wsd_pkg::*;

    logic [LenW-1:0] max_len_reg;
    logic            wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign max_len = max_len_reg;

    // Limit register, writes with paddr[2] set are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (wr_en && paddr[2] == REG_MAX_LEN) begin
            max_len_reg <= pwdata[LenW-1:0];
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_LEN) begin
            prdata = {{(32 - LenW){1'b0}}, max_len_reg};
        end
    end

endmodule

// File: hw/rtl/wsd_parser.sv
`include "websocket_frame_deframer_assert.svh"

module wsd_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic [7:0]                rx_byte,
    input  logic [wsd_pkg::LenW-1:0]  max_len,
    output wsd_pkg::wsd_result_t      res
);
    import wsd_pkg::*;

    phase_t          phase_reg, phase_next;
    logic [3:0]      opcode_reg, opcode_next;
    logic            mask_reg, mask_next;
    logic [3:0]      ext_left_reg, ext_left_next;
    logic [LenW-1:0] remain_reg, remain_next;
    logic            ovf_reg, ovf_next;
    logic [31:0]     key_reg, key_next;
    logic [2:0]      key_left_reg, key_left_next;
    logic [1:0]      key_idx_reg, key_idx_next;

    logic            len_done;
    logic            begin_pl;
    logic            pong;
    logic            ovf_now;
    logic [6:0]      len7;
    logic [7:0]      kb;

    assign len7 = rx_byte[6:0];

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            opcode_reg   <= '0;
            mask_reg     <= 1'b0;
            ext_left_reg <= '0;
            remain_reg   <= '0;
            ovf_reg      <= 1'b0;
            key_reg      <= '0;
            key_left_reg <= '0;
            key_idx_reg  <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            mask_reg     <= mask_next;
            ext_left_reg <= ext_left_next;
            remain_reg   <= remain_next;
            ovf_reg      <= ovf_next;
            key_reg      <= key_next;
            key_left_reg <= key_left_next;
            key_idx_reg  <= key_idx_next;
        end
    end

    // Key byte for the current payload position, first key byte is the MSB
    always_comb begin
        case (key_idx_reg)
            2'd0:    kb = key_reg[31:24];
            2'd1:    kb = key_reg[23:16];
            2'd2:    kb = key_reg[15:8];
            default: kb = key_reg[7:0];
        endcase
        if (!mask_reg) begin
            kb = 8'h00;
        end
    end

    // Next state and result for the byte at the input
    always_comb begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        mask_next     = mask_reg;
        ext_left_next = ext_left_reg;
        remain_next   = remain_reg;
        ovf_next      = ovf_reg;
        key_next      = key_reg;
        key_left_next = key_left_reg;
        key_idx_next  = key_idx_reg;
        len_done      = 1'b0;
        begin_pl      = 1'b0;
        pong          = 1'b0;
        ovf_now       = 1'b0;
        res           = '{valid: 1'b0, kind: EV_TEXT, data: 8'h00, last: 1'b0};

        case (phase_reg)
            PH_HDR0: begin
                opcode_next = rx_byte[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1: begin
                mask_next = rx_byte[7];
                if (opcode_reg == OP_CLOSE) begin
                    phase_next = PH_DEAD;
                    res.valid  = 1'b1;
                    res.kind   = EV_CLOSE;
                end else begin
                    if (len7 < LEN7_EXT16) begin
                        remain_next = {{(LenW - 7){1'b0}}, len7};
                        len_done    = 1'b1;
                    end else begin
                        ext_left_next = (len7 == LEN7_EXT16) ? 4'd2 : 4'd8;
                        remain_next   = '0;
                        ovf_next      = 1'b0;
                        phase_next    = PH_EXT;
                    end
                    pong = (opcode_reg == OP_PING);
                end
            end
            PH_EXT: begin
                // Bits shifted past the limit width only matter as nonzero
                ovf_now       = ovf_reg || (remain_reg[LenW-1:LenW-8] != 8'h00);
                ovf_next      = ovf_now;
                remain_next   = {remain_reg[LenW-9:0], rx_byte};
                ext_left_next = 4'(ext_left_reg - 4'd1);
                if (ext_left_next == 4'd0) begin
                    if (ovf_now || remain_next > max_len) begin
                        phase_next = PH_DEAD;
                        res.valid  = 1'b1;
                        res.kind   = EV_TOOLONG;
                    end else begin
                        len_done = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                key_next      = {key_reg[23:0], rx_byte};
                key_left_next = 3'(key_left_reg - 3'd1);
                begin_pl      = (key_left_next == 3'd0);
            end
            PH_PAYLOAD: begin
                key_idx_next = 2'(key_idx_reg + 2'd1);
                remain_next  = LenW'(remain_reg - 1'b1);
                if (remain_next == '0) begin
                    phase_next = PH_HDR0;
                end
                if (opcode_reg == OP_TEXT) begin
                    res.valid = 1'b1;
                    res.kind  = EV_TEXT;
                    res.data  = rx_byte ^ kb;
                    res.last  = (remain_next == '0);
                end
            end
            default: begin
                phase_next = PH_DEAD;
            end
        endcase

        // Length known: fetch the key if present
        if (len_done) begin
            if (mask_next) begin
                key_left_next = 3'd4;
                key_next      = '0;
                phase_next    = PH_KEY;
            end else begin
                begin_pl = 1'b1;
            end
        end

        // Header complete: start payload or close out an empty frame
        if (begin_pl) begin
            key_idx_next = '0;
            if (remain_next == '0) begin
                phase_next = PH_HDR0;
                if (opcode_reg == OP_TEXT) begin
                    res.valid = 1'b1;
                    res.kind  = EV_EMPTY;
                end
            end else begin
                phase_next = PH_PAYLOAD;
            end
        end

        // Ping wins the result slot on its length byte
        if (pong) begin
            res = '{valid: 1'b1, kind: EV_PONG, data: 8'h00, last: 1'b0};
        end
    end

    `WSD_ASSERT_NEXT(a_dead_sticks, aclk, aresetn, phase_reg == PH_DEAD, phase_reg == PH_DEAD)
    `WSD_ASSERT_NOW(a_payload_nonempty, aclk, aresetn, phase_reg == PH_PAYLOAD, remain_reg != '0)
    `WSD_ASSERT_NEXT(a_toolong_ends, aclk, aresetn, step && res.valid && res.kind == EV_TOOLONG, phase_reg == PH_DEAD)
    `WSD_ASSERT_NEXT(a_last_to_hdr, aclk, aresetn, step && res.valid && res.last, phase_reg == PH_HDR0)

endmodule

// File: hw/rtl/wsd_out_stage.sv
module wsd_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  step,
    input  wsd_pkg::wsd_result_t  res,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_event_kind,
    output logic [7:0]            m_payload_byte,
    output logic                  m_last_of_message
);
    import wsd_pkg::*;

    logic       valid_reg;
    ev_kind_t   kind_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    // Take a byte whenever the result slot is free or drains this cycle
    assign s_ready = !valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    assign m_valid           = valid_reg;
    assign m_event_kind      = kind_reg;
    assign m_payload_byte    = data_reg;
    assign m_last_of_message = last_reg;

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (step) begin
            valid_reg <= res.valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (step && res.valid) begin
            kind_reg <= res.kind;
            data_reg <= res.data;
            last_reg <= res.last;
        end
    end

endmodule
